>>> src/edge_flag_coverage_rasterizer_macros.svh
// Assertion macros shared by the edge-flag coverage rasterizer RTL.
// Define NO_ASSERTIONS to compile the checks out; no other dependencies.
`ifndef EDGE_FLAG_COVERAGE_RASTERIZER_MACROS_SVH
`define EDGE_FLAG_COVERAGE_RASTERIZER_MACROS_SVH

`ifndef NO_ASSERTIONS

// checked only while reset is low
`define EFCR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define EFCR_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define EFCR_ASSERT(label, clk, rst, prop, msg)
`define EFCR_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

>>> src/efcr_pkg.sv
// Shared types, codes and helpers of the edge-flag coverage rasterizer.
// No dependencies; used by the top level and the testbench.
`default_nettype none

package efcr_pkg;

   localparam int SAMPLES   = 32;
   localparam int FLAGS_W   = 32;
   localparam int WIND_W    = 16;
   localparam int ENTRY_W   = FLAGS_W + WIND_W;
   localparam int REQ_W     = 88;
   localparam int RSP_W     = 56;

   // action codes of an input item
   localparam logic [1:0] ACT_EDGE    = 2'd0;
   localparam logic [1:0] ACT_RESOLVE = 2'd1;
   localparam logic [1:0] ACT_SKIP    = 2'd2;
   localparam logic [1:0] ACT_END     = 2'd3;

   // fill rule codes
   localparam logic RULE_EVEN_ODD = 1'b0;
   localparam logic RULE_WINDING  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_WALK,
      ST_RES_RD,
      ST_RES_WB
   } efcr_state_type;

   // sparse sample pattern in 32nds of a pixel, indexed by sample row
   localparam logic [4:0] PATTERN [SAMPLES] = '{
      5'd28, 5'd13, 5'd6,  5'd23, 5'd0,  5'd17, 5'd10, 5'd27,
      5'd4,  5'd21, 5'd14, 5'd31, 5'd8,  5'd25, 5'd18, 5'd3,
      5'd12, 5'd29, 5'd22, 5'd7,  5'd16, 5'd1,  5'd26, 5'd11,
      5'd20, 5'd5,  5'd30, 5'd15, 5'd24, 5'd9,  5'd2,  5'd19
   };

   // population count of a 32-bit word, 0..32
   function automatic logic [5:0] popcount32(input logic [31:0] v);
      logic [31:0] c;
      logic [5:0]  sum;
      c   = v - ((v >> 1) & 32'h5555_5555);
      c   = (c & 32'h3333_3333) + ((c >> 2) & 32'h3333_3333);
      c   = (c + (c >> 4)) & 32'h0f0f_0f0f;
      sum = 6'(c[7:0]) + 6'(c[15:8]) + 6'(c[23:16]) + 6'(c[31:24]);
      return sum;
   endfunction

endpackage

`default_nettype wire

>>> src/efcr_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none

module efcr_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 2048
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> src/edge_flag_coverage_rasterizer.sv
// Top level of the edge-flag coverage rasterizer: sequencer, walk unit, resolve logic.
// Depends on efcr_pkg, efcr_ram and edge_flag_coverage_rasterizer_macros.svh.
//
// Usage:
//   req_* is a stream of scanline work items: edge runs, pixel resolves, pixel
//   skips and end-of-scanline markers. rsp_* carries one result per resolve:
//   pixel, coverage (set samples times 8), full-cover flag and running mask.
//   csr_wr_en/csr_wr_data write the fill rule (0 even-odd, 1 winding); write it
//   only while no item is in flight.
// Timing:
//   an edge run walks its subsample rows (up to 32) after the transfer; the
//   walk adder, the flag RAM read port and its write port do one row
//   read-modify-write per cycle, with forwarding between adjacent rows.
//   A resolve or skip goes through a RAM read step and a write-back step; the
//   result shows on rsp_* in the cycle after the write-back.
//   End of scanline sweeps the flag RAM, one entry per cycle, with req_tready
//   low until every entry is cleared.
// Reset:
//   synchronous; afterwards the same sweep clears the RAM
//   before the first transfer is taken. The fill rule resets to winding.
// Back-pressure:
//   a result waits in the output register; edges and skips keep going, a
//   further resolve waits in its write-back step until the result is taken.
`default_nettype none

module edge_flag_coverage_rasterizer #(
   parameter int MAX_WIDTH = 2048
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   // request channel
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   // tdata: edge_x[31:0], edge_slope[63:32], first_sample[68:64],
   //        sample_count[74:69], winding_sign[76:75], pixel_index[87:77]
   input  wire logic [efcr_pkg::REQ_W-1:0] req_tdata,
   // tuser: action[1:0]
   input  wire logic [1:0]                req_tuser,
   // response channel
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   // tdata: out_pixel[10:0], coverage[19:11], full_cover[20],
   //        coverage_mask[52:21], zero pad
   output logic      [efcr_pkg::RSP_W-1:0] rsp_tdata,
   // fill rule register
   input  wire logic                      csr_wr_en,
   input  wire logic                      csr_wr_data
);

   import efcr_pkg::*;

   `include "edge_flag_coverage_rasterizer_macros.svh"

   localparam int AW = $clog2(MAX_WIDTH);
   localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_WIDTH - 1);
   localparam logic [15:0]   WIDTH_LIM = 16'(MAX_WIDTH);

   // request fields
   logic [1:0]  req_action;
   logic [31:0] req_edge_x;
   logic [31:0] req_edge_slope;
   logic [4:0]  req_first_sample;
   logic [5:0]  req_sample_count;
   logic [1:0]  req_winding_sign;
   logic [10:0] req_pixel_index;

   assign req_action       = req_tuser;
   assign req_edge_x       = req_tdata[31:0];
   assign req_edge_slope   = req_tdata[63:32];
   assign req_first_sample = req_tdata[68:64];
   assign req_sample_count = req_tdata[74:69];
   assign req_winding_sign = req_tdata[76:75];
   assign req_pixel_index  = req_tdata[87:77];

   efcr_state_type state_ff, state_in;

   logic            fill_rule_ff, fill_rule_in;
   logic [AW-1:0]   clr_addr_ff, clr_addr_in;

   // latched item
   logic            mode_ff, mode_in;
   logic [31:0]     acc_ff, acc_in;
   logic [31:0]     slope_ff, slope_in;
   logic [4:0]      samp_ff, samp_in;
   logic [5:0]      cnt_ff, cnt_in;
   logic [15:0]     sgn_ff, sgn_in;
   logic [1:0]      act_ff, act_in;
   logic [10:0]     pix_ff, pix_in;
   logic            pix_ok_ff, pix_ok_in;

   // write-back stage of the walk
   logic                b_valid_ff, b_valid_in;
   logic [AW-1:0]       b_addr_ff, b_addr_in;
   logic [4:0]          b_samp_ff, b_samp_in;
   logic                b_fwd_ff, b_fwd_in;
   logic [ENTRY_W-1:0]  fwd_ff, fwd_in;

   // running coverage state
   logic [31:0]     mask_ff, mask_in;
   logic [15:0]     total_ff, total_in;

   // output register
   logic            rsp_valid_ff, rsp_valid_in;
   logic [10:0]     rsp_pixel_ff, rsp_pixel_in;
   logic [8:0]      rsp_cov_ff, rsp_cov_in;
   logic            rsp_full_ff, rsp_full_in;
   logic [31:0]     rsp_mask_ff, rsp_mask_in;

   // RAM ports
   logic                ram_wr_en;
   logic [AW-1:0]       ram_wr_addr;
   logic [ENTRY_W-1:0]  ram_wr_data;
   logic                ram_rd_en;
   logic [AW-1:0]       ram_rd_addr;
   logic [ENTRY_W-1:0]  ram_rd_data;

   // walk unit signals
   logic [31:0]         pos;
   logic [15:0]         px;
   logic                px_ok;
   logic                last_row;
   logic [ENTRY_W-1:0]  b_old;
   logic [31:0]         b_bit;
   logic [31:0]         b_flags;
   logic [15:0]         b_wind;
   logic [ENTRY_W-1:0]  b_new;

   // resolve signals
   logic [15:0]         req_pix16;
   logic                accept;
   logic                slot_free;
   logic                res_go;
   logic [31:0]         res_flags;
   logic [15:0]         res_wind;
   logic [15:0]         res_total;
   logic [31:0]         res_mask;

   assign accept    = req_tvalid && req_tready;
   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign req_pix16 = {5'd0, req_pixel_index};

   // walk unit: sample position of the current row and the pixel it hits
   assign pos      = acc_ff + {16'd0, PATTERN[samp_ff], 11'd0};
   assign px       = pos[31] ? 16'd0 : {1'b0, pos[30:16]};
   assign px_ok    = px < WIDTH_LIM;
   assign last_row = (cnt_ff == 6'd1) || (samp_ff == 5'(SAMPLES - 1));

   // walk write-back: set or toggle the sample bit, count the winding
   assign b_old   = b_fwd_ff ? fwd_ff : ram_rd_data;
   assign b_bit   = 32'd1 << b_samp_ff;
   assign b_flags = (mode_ff == RULE_WINDING) ? (b_old[FLAGS_W-1:0] | b_bit)
                                              : (b_old[FLAGS_W-1:0] ^ b_bit);
   assign b_wind  = (mode_ff == RULE_WINDING) ? (b_old[ENTRY_W-1:FLAGS_W] + sgn_ff)
                                              : b_old[ENTRY_W-1:FLAGS_W];
   assign b_new   = {b_wind, b_flags};

   // resolve: fold the pixel flags into the running mask
   assign res_go    = (state_ff == ST_RES_WB) && ((act_ff == ACT_SKIP) || slot_free);
   assign res_flags = pix_ok_ff ? ram_rd_data[FLAGS_W-1:0] : 32'd0;
   assign res_wind  = pix_ok_ff ? ram_rd_data[ENTRY_W-1:FLAGS_W] : 16'd0;
   assign res_total = total_ff + res_wind;

   always_comb begin
      if ((act_ff == ACT_RESOLVE) && (mode_ff == RULE_WINDING)) begin
         res_mask = (res_total == 16'd0) ? res_flags : (mask_ff | res_flags);
      end else begin
         res_mask = mask_ff ^ res_flags;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_action) inside
                  ACT_EDGE:              state_in = (req_sample_count != 6'd0) ? ST_WALK
                                                                             : ST_IDLE;
                  ACT_RESOLVE, ACT_SKIP: state_in = ST_RES_RD;
                  ACT_END:               state_in = ST_CLEAR;
                  default:               state_in = ST_IDLE;
               endcase
            end
         end
         ST_CLEAR: begin
            if (clr_addr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_WALK: begin
            if (last_row) begin
               state_in = ST_IDLE;
            end
         end
         ST_RES_RD: state_in = ST_RES_WB;
         ST_RES_WB: begin
            if (res_go) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_tready   = (state_ff == ST_IDLE);
      fill_rule_in = csr_wr_en ? csr_wr_data : fill_rule_ff;
      clr_addr_in  = clr_addr_ff;
      mode_in      = mode_ff;
      acc_in       = acc_ff;
      slope_in     = slope_ff;
      samp_in      = samp_ff;
      cnt_in       = cnt_ff;
      sgn_in       = sgn_ff;
      act_in       = act_ff;
      pix_in       = pix_ff;
      pix_ok_in    = pix_ok_ff;
      b_valid_in   = 1'b0;
      b_addr_in    = b_addr_ff;
      b_samp_in    = b_samp_ff;
      b_fwd_in     = 1'b0;
      fwd_in       = fwd_ff;
      mask_in      = mask_ff;
      total_in     = total_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_pixel_in = rsp_pixel_ff;
      rsp_cov_in   = rsp_cov_ff;
      rsp_full_in  = rsp_full_ff;
      rsp_mask_in  = rsp_mask_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = b_addr_ff;
      ram_wr_data  = b_new;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = px[AW-1:0];

      // walk write-back runs whenever a row is in flight
      if (b_valid_ff) begin
         ram_wr_en = 1'b1;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               mode_in   = fill_rule_ff;
               acc_in    = req_edge_x;
               slope_in  = req_edge_slope;
               samp_in   = req_first_sample;
               cnt_in    = req_sample_count;
               sgn_in    = {{14{req_winding_sign[1]}}, req_winding_sign};
               act_in    = req_action;
               pix_in    = req_pixel_index;
               pix_ok_in = req_pix16 < WIDTH_LIM;
               if (req_action == ACT_END) begin
                  clr_addr_in = '0;
                  mask_in     = 32'd0;
                  total_in    = 16'd0;
               end
            end
         end
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_addr_ff;
            ram_wr_data = '0;
            clr_addr_in = clr_addr_ff + AW'(1);
         end
         ST_WALK: begin
            // issue the row read, forward if the row before writes the same pixel
            ram_rd_en  = px_ok;
            b_valid_in = px_ok;
            b_addr_in  = px[AW-1:0];
            b_samp_in  = samp_ff;
            b_fwd_in   = px_ok && b_valid_ff && (b_addr_ff == px[AW-1:0]);
            fwd_in     = b_new;
            acc_in     = acc_ff + slope_ff;
            samp_in    = samp_ff + 5'd1;
            cnt_in     = cnt_ff - 6'd1;
         end
         ST_RES_RD: begin
            ram_rd_en   = pix_ok_ff;
            ram_rd_addr = AW'(pix_ff);
         end
         ST_RES_WB: begin
            if (res_go) begin
               ram_wr_en   = pix_ok_ff;
               ram_wr_addr = AW'(pix_ff);
               ram_wr_data = '0;
               mask_in     = res_mask;
               if ((act_ff == ACT_RESOLVE) && (mode_ff == RULE_WINDING)) begin
                  total_in = res_total;
               end
               if (act_ff == ACT_RESOLVE) begin
                  rsp_valid_in = 1'b1;
                  rsp_pixel_in = pix_ff;
                  rsp_cov_in   = {popcount32(res_mask), 3'd0};
                  rsp_full_in  = (res_mask == 32'hffff_ffff);
                  rsp_mask_in  = res_mask;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         fill_rule_ff <= RULE_WINDING;
         clr_addr_ff  <= '0;
         b_valid_ff   <= 1'b0;
         b_fwd_ff     <= 1'b0;
         mask_ff      <= 32'd0;
         total_ff     <= 16'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_rule_ff <= fill_rule_in;
         clr_addr_ff  <= clr_addr_in;
         b_valid_ff   <= b_valid_in;
         b_fwd_ff     <= b_fwd_in;
         mask_ff      <= mask_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      acc_ff       <= acc_in;
      slope_ff     <= slope_in;
      samp_ff      <= samp_in;
      cnt_ff       <= cnt_in;
      sgn_ff       <= sgn_in;
      act_ff       <= act_in;
      pix_ff       <= pix_in;
      pix_ok_ff    <= pix_ok_in;
      b_addr_ff    <= b_addr_in;
      b_samp_ff    <= b_samp_in;
      fwd_ff       <= fwd_in;
      rsp_pixel_ff <= rsp_pixel_in;
      rsp_cov_ff   <= rsp_cov_in;
      rsp_full_ff  <= rsp_full_in;
      rsp_mask_ff  <= rsp_mask_in;
   end

   // per-pixel flags and winding sums
   efcr_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_WIDTH)
   ) u_flag_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'd0, rsp_mask_ff, rsp_full_ff, rsp_cov_ff, rsp_pixel_ff};

   // checks
   `EFCR_ASSERT(a_no_walk_during_clear, clock, reset,
      (state_ff == ST_CLEAR) |-> !b_valid_ff, "walk write-back during RAM sweep")
   `EFCR_ASSERT(a_fwd_needs_row, clock, reset,
      b_fwd_ff |-> b_valid_ff, "forwarded flags without a row in flight")
   `EFCR_ASSERT(a_walk_count, clock, reset,
      (state_ff == ST_WALK) |-> (cnt_ff != 6'd0), "walk with no rows left")
   `EFCR_ASSERT(a_full_cover, clock, reset,
      (rsp_valid_ff && rsp_full_ff) |-> (rsp_cov_ff == 9'd256), "full cover without 256")
   `EFCR_ASSERT_ALWAYS(a_reset_sweeps, clock,
      $past(reset) |-> (state_ff == ST_CLEAR), "no RAM sweep after reset")

endmodule

`default_nettype wire

>>> test/tb_edge_flag_coverage_rasterizer.sv
// Self-checking testbench for edge_flag_coverage_rasterizer: directed table, then random
// scanlines under random stalls on both streams, every result checked against a predictor or a table entry.
// Depends on efcr_pkg and the rasterizer RTL only.
`timescale 1ns / 100ps

module tb_edge_flag_coverage_rasterizer;
   import efcr_pkg::*;

   localparam int MAX_WIDTH   = 2048;
   localparam int N_RANDOM    = 1300;
   localparam int N_PHASES    = 6;
   localparam int SETTLE      = MAX_WIDTH + 64;
   localparam int CYCLE_LIMIT = 3 * (N_RANDOM + 64) * (MAX_WIDTH + 128);

   // sample row offsets in 32nds of a pixel
   localparam logic [4:0] ROW_OFFSET_32NDS [32] = '{
      5'd28, 5'd13, 5'd6,  5'd23, 5'd0,  5'd17, 5'd10, 5'd27,
      5'd4,  5'd21, 5'd14, 5'd31, 5'd8,  5'd25, 5'd18, 5'd3,
      5'd12, 5'd29, 5'd22, 5'd7,  5'd16, 5'd1,  5'd26, 5'd11,
      5'd20, 5'd5,  5'd30, 5'd15, 5'd24, 5'd9,  5'd2,  5'd19
   };

   // fill rule of each random phase
   localparam logic PHASE_RULE [N_PHASES] = '{
      RULE_EVEN_ODD, RULE_WINDING, RULE_EVEN_ODD, RULE_WINDING, RULE_WINDING, RULE_EVEN_ODD
   };

   typedef struct {
      logic [1:0]  action;
      logic [31:0] x;
      logic [31:0] slope;
      logic [4:0]  first;
      logic [5:0]  count;
      logic [1:0]  sign;
      logic [10:0] pixel;
   } raster_item_type;

   typedef struct {
      logic [10:0] pixel;
      logic [8:0]  coverage;
      logic        full;
      logic [31:0] mask;
   } coverage_result_type;

   typedef struct {
      bit                  is_cfg;
      logic                rule;
      raster_item_type     item;
      bit                  typed;
      coverage_result_type want;
   } stim_row_type;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata;
   logic [1:0] req_tuser;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;
   logic csr_wr_en;
   logic csr_wr_data;

   // predictor state
   logic [31:0] flag_mem [MAX_WIDTH];
   logic [15:0] wind_mem [MAX_WIDTH];
   logic [31:0] run_mask;
   logic [15:0] wind_total;
   logic        fill_rule;

   coverage_result_type coverage_expected [$];
   stim_row_type        directed [$];

   // typed expectation travelling with the item on the bus
   bit                  item_typed;
   coverage_result_type item_want;

   int fail_count;
   int cycle_count;
   int n_edges, n_resolves, n_skips, n_ends, n_full, n_cfg;
   int calm_left;
   int scan_base;

   edge_flag_coverage_rasterizer #(
      .MAX_WIDTH(MAX_WIDTH)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic logic [8:0] coverage_of(logic [31:0] m);
      logic [8:0] n;
      n = '0;
      for (int i = 0; i < 32; i++) n += 9'(m[i]);
      return 9'(n * 8);
   endfunction

   // applies one item to the predicted state; returns 1 when it yields a result
   function automatic bit predict_coverage(raster_item_type it,
                                           output coverage_result_type res);
      logic [31:0] xr, pos, flags;
      logic [15:0] sgn16, ws;
      int s, k, px;
      bit ok;
      res   = '{default: '0};
      ok    = int'(it.pixel) < MAX_WIDTH;
      flags = ok ? flag_mem[it.pixel] : '0;
      ws    = ok ? wind_mem[it.pixel] : '0;
      sgn16 = {{14{it.sign[1]}}, it.sign};
      case (it.action)
         ACT_EDGE: begin
            xr = it.x;
            s  = int'(it.first);
            for (k = 0; k < int'(it.count) && s < SAMPLES; k++) begin
               pos = xr + (32'(ROW_OFFSET_32NDS[s]) << 11);
               px  = pos[31] ? 0 : int'(pos >> 16);
               if (px < MAX_WIDTH) begin
                  if (fill_rule == RULE_WINDING) begin
                     flag_mem[px] = flag_mem[px] | (32'd1 << s);
                     wind_mem[px] = wind_mem[px] + sgn16;
                  end else begin
                     flag_mem[px] = flag_mem[px] ^ (32'd1 << s);
                  end
               end
               xr = xr + it.slope;
               s++;
            end
            return 1'b0;
         end
         ACT_END: begin
            for (int i = 0; i < MAX_WIDTH; i++) begin
               flag_mem[i] = '0;
               wind_mem[i] = '0;
            end
            run_mask   = '0;
            wind_total = '0;
            return 1'b0;
         end
         default: begin
            if (ok) begin
               flag_mem[it.pixel] = '0;
               wind_mem[it.pixel] = '0;
            end
            if (it.action == ACT_SKIP) begin
               run_mask = run_mask ^ flags;
               return 1'b0;
            end
            if (fill_rule == RULE_WINDING) begin
               wind_total = wind_total + ws;
               run_mask   = (wind_total == 16'd0) ? flags : (run_mask | flags);
            end else begin
               run_mask = run_mask ^ flags;
            end
            res.pixel    = it.pixel;
            res.coverage = coverage_of(run_mask);
            res.full     = (run_mask == 32'hffff_ffff);
            res.mask     = run_mask;
            return 1'b1;
         end
      endcase
   endfunction

   task automatic check_coverage(coverage_result_type want, coverage_result_type got);
      if (got.pixel !== want.pixel) begin
         $error("out_pixel: expected %0d, got %0d", want.pixel, got.pixel);
         fail_count++;
      end
      if (got.coverage !== want.coverage) begin
         $error("coverage: expected %0d, got %0d", want.coverage, got.coverage);
         fail_count++;
      end
      if (got.full !== want.full) begin
         $error("full_cover: expected %0b, got %0b", want.full, got.full);
         fail_count++;
      end
      if (got.mask !== want.mask) begin
         $error("coverage_mask: expected %08h, got %08h", want.mask, got.mask);
         fail_count++;
      end
   endtask

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin : monitor
      raster_item_type     acc;
      coverage_result_type pred;
      coverage_result_type got;
      bit                  has;
      if (!reset) begin
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $error("timeout after %0d cycles", cycle_count);
            $display("TB_ERROR");
            $finish;
         end
         // register write
         if (csr_wr_en) begin
            fill_rule = csr_wr_data;
            n_cfg++;
         end
         // accepted request transfer
         if (req_tvalid && req_tready) begin
            acc.action = req_tuser;
            acc.x      = req_tdata[31:0];
            acc.slope  = req_tdata[63:32];
            acc.first  = req_tdata[68:64];
            acc.count  = req_tdata[74:69];
            acc.sign   = req_tdata[76:75];
            acc.pixel  = req_tdata[87:77];
            case (acc.action)
               ACT_EDGE:    n_edges++;
               ACT_RESOLVE: n_resolves++;
               ACT_SKIP:    n_skips++;
               default:     n_ends++;
            endcase
            has = predict_coverage(acc, pred);
            if (has) coverage_expected.push_back(item_typed ? item_want : pred);
         end
         // accepted response transfer
         if (rsp_tvalid && rsp_tready) begin
            got.pixel    = rsp_tdata[10:0];
            got.coverage = rsp_tdata[19:11];
            got.full     = rsp_tdata[20];
            got.mask     = rsp_tdata[52:21];
            if (got.full) n_full++;
            if (coverage_expected.size() == 0) begin
               $error("result for pixel %0d with none expected", got.pixel);
               fail_count++;
            end else begin
               check_coverage(coverage_expected.pop_front(), got);
            end
         end
      end
   end

   // ---------------------------------------------------------------- receiver

   initial begin : receiver
      int mode_left, stall_left, r;
      bit noisy;
      mode_left  = 0;
      stall_left = 0;
      noisy      = 1'b0;
      forever begin
         @(negedge clock);
         if (mode_left == 0) begin
            noisy     = ($urandom_range(0, 2) != 0);
            mode_left = $urandom_range(20, 200);
         end
         mode_left--;
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else if (!noisy) begin
            rsp_tready <= 1'b1;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
               rsp_tready <= 1'b1;
            end else if (r < 95) begin
               rsp_tready <= 1'b0;
               stall_left = $urandom_range(0, 2);
            end else begin
               rsp_tready <= 1'b0;
               stall_left = $urandom_range(9, 39);
            end
         end
      end
   end

   // ---------------------------------------------------------------- stimulus helpers

   function automatic stim_row_type item_row(logic [1:0] act, logic [31:0] x,
                                             logic [31:0] slope, int first, int count,
                                             logic [1:0] sgn, int px);
      stim_row_type r;
      r              = '{default: '0};
      r.item.action  = act;
      r.item.x       = x;
      r.item.slope   = slope;
      r.item.first   = 5'(first);
      r.item.count   = 6'(count);
      r.item.sign    = sgn;
      r.item.pixel   = 11'(px);
      return r;
   endfunction

   function automatic stim_row_type with_result(stim_row_type r, int px, int cov, bit full,
                                                logic [31:0] mask);
      r.typed         = 1'b1;
      r.want.pixel    = 11'(px);
      r.want.coverage = 9'(cov);
      r.want.full     = full;
      r.want.mask     = mask;
      return r;
   endfunction

   function automatic stim_row_type cfg_row(logic rule);
      stim_row_type r;
      r        = '{default: '0};
      r.is_cfg = 1'b1;
      r.rule   = rule;
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 49) == 0) calm_left = $urandom_range(20, 80);
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // random item clustered around the current scanline window
   function automatic raster_item_type random_item(int base);
      raster_item_type it;
      int pick, roll;
      it.action = ACT_EDGE;
      it.x      = $urandom;
      it.slope  = $urandom;
      it.first  = 5'($urandom);
      it.count  = 6'($urandom);
      it.sign   = 2'($urandom);
      it.pixel  = 11'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
         it.action = ACT_END;
      end else if (pick < 10) begin
         it.action = ACT_SKIP;
      end else if (pick < 40) begin
         it.action = ACT_RESOLVE;
      end
      if (it.action == ACT_EDGE) begin
         roll = $urandom_range(0, 19);
         if (roll == 1) begin
            it.x = 32'h0 - 32'($urandom_range(1, 32'h3_ffff));
         end else if (roll != 0) begin
            it.x = (32'(base + $urandom_range(0, 7)) << 16) | 32'($urandom_range(0, 16'hffff));
         end
         if (roll != 0) begin
            roll = $urandom_range(0, 9);
            if (roll < 6)
               it.slope = 32'($urandom_range(0, 32'h4_0000)) - 32'h2_0000;
            else if (roll < 8)
               it.slope = '0;
            else if (roll == 8)
               it.slope = $urandom_range(0, 1) ? 32'h0001_0000 : 32'hffff_0000;
         end
         if ($urandom_range(0, 9) != 0) it.count = 6'($urandom_range(1, 32));
         if ($urandom_range(0, 9) != 0) it.sign = $urandom_range(0, 1) ? 2'b01 : 2'b11;
      end else if ($urandom_range(0, 19) != 0) begin
         it.pixel = 11'(base + $urandom_range(0, 9));
      end
      return it;
   endfunction

   task automatic send_item(raster_item_type it, bit typed, coverage_result_type want);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {it.pixel, it.sign, it.count, it.first, it.slope, it.x};
      req_tuser  <= it.action;
      item_typed <= typed;
      item_want  <= want;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // hold the sender until every expected result has come back
   task automatic wait_results_drained();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (coverage_expected.size() != 0);
   endtask

   // write the fill rule once the block has gone quiet
   task automatic set_fill_rule(logic rule);
      wait_results_drained();
      repeat (SETTLE) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= rule;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // ---------------------------------------------------------------- main sequence

   initial begin : stimulus
      raster_item_type     it;
      coverage_result_type none;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      rsp_tready  = 1'b0;
      csr_wr_en   = 1'b0;
      csr_wr_data = 1'b0;
      item_typed  = 1'b0;
      item_want   = '{default: '0};
      none        = '{default: '0};
      fail_count  = 0;
      cycle_count = 0;
      calm_left   = 0;
      scan_base   = 0;
      n_edges = 0; n_resolves = 0; n_skips = 0; n_ends = 0; n_full = 0; n_cfg = 0;
      fill_rule   = RULE_WINDING;
      run_mask    = '0;
      wind_total  = '0;
      for (int i = 0; i < MAX_WIDTH; i++) begin
         flag_mem[i] = '0;
         wind_mem[i] = '0;
      end

      // winding rule, fresh state, extremes of the fields
      directed.push_back(cfg_row(RULE_WINDING));
      directed.push_back(with_result(item_row(ACT_RESOLVE, 0, 0, 0, 1, 2'b01, 0),
                                     0, 0, 0, 32'h0));
      directed.push_back(with_result(item_row(ACT_RESOLVE, 0, 0, 0, 1, 2'b01, 2047),
                                     2047, 0, 0, 32'h0));
      directed.push_back(item_row(ACT_EDGE, 32'h0, 32'h0, 0, 32, 2'b01, 0));
      directed.push_back(with_result(item_row(ACT_RESOLVE, 0, 0, 0, 1, 2'b01, 0),
                                     0, 256, 1, 32'hffff_ffff));
      directed.push_back(item_row(ACT_END, 0, 0, 0, 0, 2'b00, 0));
      // zero rows, left of bound with sign pattern two, right of bound, walk past last row
      directed.push_back(item_row(ACT_EDGE, 32'h7fff_ffff, 32'h8000_0000, 0, 0, 2'b01, 0));
      directed.push_back(item_row(ACT_EDGE, 32'h8000_0000, 32'h0, 31, 1, 2'b10, 0));
      directed.push_back(item_row(ACT_EDGE, 32'h7fff_0000, 32'h0, 5, 63, 2'b00, 0));
      directed.push_back(item_row(ACT_EDGE, 32'h0000_0800, 32'h0000_8000, 31, 32, 2'b01, 0));
      directed.push_back(item_row(ACT_RESOLVE, 0, 0, 0, 0, 2'b00, 0));
      directed.push_back(item_row(ACT_SKIP, 0, 0, 0, 0, 2'b00, 0));
      directed.push_back(item_row(ACT_EDGE, 32'h0005_0000, 32'h0001_0000, 0, 32, 2'b11, 0));
      directed.push_back(item_row(ACT_RESOLVE, 0, 0, 0, 0, 2'b00, 5));
      directed.push_back(item_row(ACT_SKIP, 0, 0, 0, 0, 2'b00, 2047));
      directed.push_back(item_row(ACT_EDGE, 32'h07ff_0000, 32'hffff_0000, 0, 32, 2'b01, 0));
      directed.push_back(item_row(ACT_RESOLVE, 0, 0, 0, 0, 2'b00, 2047));
      directed.push_back(item_row(ACT_END, 0, 0, 0, 0, 2'b00, 0));
      // even-odd toggling
      directed.push_back(cfg_row(RULE_EVEN_ODD));
      directed.push_back(item_row(ACT_EDGE, 32'h0, 32'h0, 0, 32, 2'b01, 0));
      directed.push_back(item_row(ACT_EDGE, 32'h0, 32'h0, 0, 16, 2'b01, 0));
      directed.push_back(item_row(ACT_RESOLVE, 0, 0, 0, 0, 2'b00, 0));
      directed.push_back(item_row(ACT_EDGE, 32'h0003_0000, 32'hffff_8000, 8, 40, 2'b10, 0));
      // opposite edges cancel, total stays zero so the mask is replaced
      directed.push_back(cfg_row(RULE_WINDING));
      directed.push_back(item_row(ACT_EDGE, 32'h0003_0000, 32'h0, 8, 8, 2'b01, 0));
      directed.push_back(item_row(ACT_EDGE, 32'h0003_0000, 32'h0, 8, 8, 2'b11, 0));
      directed.push_back(item_row(ACT_RESOLVE, 0, 0, 0, 0, 2'b00, 3));

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed[i]) begin
         if (directed[i].is_cfg)
            set_fill_rule(directed[i].rule);
         else
            send_item(directed[i].item, directed[i].typed, directed[i].want);
      end

      // random scanlines, one fill rule per phase
      for (int p = 0; p < N_PHASES; p++) begin
         set_fill_rule(PHASE_RULE[p]);
         for (int n = 0; n < N_RANDOM / N_PHASES; n++) begin
            if (n == 100 || $urandom_range(0, 199) == 0) wait_results_drained();
            it = random_item(scan_base);
            send_item(it, 1'b0, none);
            if (it.action == ACT_END || $urandom_range(0, 59) == 0) begin
               case ($urandom_range(0, 3))
                  0:       scan_base = $urandom_range(0, 7);
                  1:       scan_base = $urandom_range(MAX_WIDTH - 8, MAX_WIDTH - 1);
                  default: scan_base = $urandom_range(0, MAX_WIDTH - 1);
               endcase
            end
         end
      end

      // let the tail of the work finish
      wait_results_drained();
      repeat (SETTLE) @(negedge clock);
      if (coverage_expected.size() != 0) begin
         $error("%0d expected results never arrived", coverage_expected.size());
         fail_count++;
      end

      $display("run covered %0d edge runs, %0d resolves, %0d skips, %0d scanline ends",
               n_edges, n_resolves, n_skips, n_ends);
      $display("%0d fill rule writes, %0d fully covered results, %0d cycles",
               n_cfg, n_full, cycle_count);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
